@@ hw/rtl/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] HIGH_TAG = 6'b110110;
  localparam logic [5:0] LOW_TAG  = 6'b110111;

  typedef enum logic [1:0] {
    ST_OK,
    ST_MISSING_LOW,
    ST_HIGH_NOT_LOW,
    ST_UNPAIRED_LOW
  } status_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_t         status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hw/rtl/u16u8_if.sv @@
// ----------------------------------------------------------------------------
// u16u8_if
// Channel interfaces: UTF-16 code units in, UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_text;

  modport source (output valid, output code_unit, output end_of_text, input ready);
  modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output run_last, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input status,
                  output ready);
endinterface

@@ hw/rtl/utf16_to_utf8_transcoder_top.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and errors.
//
//   channel   dir  payload
//   unit_in   in   code_unit[15:0], end_of_text
//   byte_out  out  out_byte[7:0], run_last, status[1:0]
//
// One output word per cycle while the receiver holds ready and jobs wait: a
// unit gives 1 to 3 bytes, 4 for the low half of a pair, 1 word for an error
// and none for a held high surrogate; the back end serialises the bytes.
// A four-entry job queue lets input words keep arriving while bytes drain.
// Synchronous reset clears the pending surrogate, the queue and the output.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top (
  input  logic           clk,
  input  logic           rst,
  u16u8_unit_if.sink     unit_in,
  u16u8_byte_if.source   byte_out
);

  u16u8_pkg::job_t    push_job;
  u16u8_pkg::job_t    head;
  u16u8_pkg::q_stat_t q_stat;
  logic               push;
  logic               pop;

  u16u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .unit_in  (unit_in),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  u16u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .byte_out (byte_out)
  );

endmodule

@@ hw/rtl/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, holds a high surrogate until the next word and turns
// every other word into a job of up to four UTF-8 bytes or one error result.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                clk,
  input  logic                rst,
  u16u8_unit_if.sink          unit_in,
  input  u16u8_pkg::q_stat_t  q_stat,
  output logic                push,
  output u16u8_pkg::job_t     job
);

  logic       pending_valid;
  logic [9:0] pending_high_bits;
  logic       pending_valid_next;
  logic [9:0] pending_high_bits_next;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       emit;
  logic [4:0] plane;
  logic [15:0] cu;

  assign unit_in.ready = !q_stat.full;
  assign accept        = unit_in.valid && unit_in.ready;
  assign cu            = unit_in.code_unit;
  assign is_high       = (cu[15:10] == u16u8_pkg::HIGH_TAG);
  assign is_low        = (cu[15:10] == u16u8_pkg::LOW_TAG);
  assign plane         = {1'b0, pending_high_bits[9:6]} + 5'd1;
  assign push          = accept && emit;

  always_comb begin
    emit                   = 1'b1;
    pending_valid_next     = 1'b0;
    pending_high_bits_next = pending_high_bits;
    job.bytes              = '0;
    job.last_idx           = 2'd0;
    job.status             = u16u8_pkg::ST_OK;
    if (pending_valid) begin
      if (!is_low) begin
        job.status = u16u8_pkg::ST_HIGH_NOT_LOW;
      end else begin
        job.bytes[0] = {5'b11110, plane[4:2]};
        job.bytes[1] = {2'b10, plane[1:0], pending_high_bits[5:2]};
        job.bytes[2] = {2'b10, pending_high_bits[1:0], cu[9:6]};
        job.bytes[3] = {2'b10, cu[5:0]};
        job.last_idx = 2'd3;
      end
    end else if (is_high) begin
      if (unit_in.end_of_text) begin
        job.status = u16u8_pkg::ST_MISSING_LOW;
      end else begin
        emit                   = 1'b0;
        pending_valid_next     = 1'b1;
        pending_high_bits_next = cu[9:0];
      end
    end else if (is_low) begin
      job.status = u16u8_pkg::ST_UNPAIRED_LOW;
    end else if (cu[15:7] == 9'd0) begin
      job.bytes[0] = cu[7:0];
    end else if (cu[15:11] == 5'd0) begin
      job.bytes[0] = {3'b110, cu[10:6]};
      job.bytes[1] = {2'b10, cu[5:0]};
      job.last_idx = 2'd1;
    end else begin
      job.bytes[0] = {4'b1110, cu[15:12]};
      job.bytes[1] = {2'b10, cu[11:6]};
      job.bytes[2] = {2'b10, cu[5:0]};
      job.last_idx = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
    end else if (accept) begin
      pending_valid <= pending_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_high_bits <= pending_high_bits_next;
    end
  end

endmodule

@@ hw/rtl/u16u8_queue.sv @@
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u16u8_pkg::job_t     push_job,
  input  logic                pop,
  output u16u8_pkg::job_t     head,
  output u16u8_pkg::q_stat_t  q_stat
);

  u16u8_pkg::job_t               slots [u16u8_pkg::QUEUE_DEPTH];
  logic [u16u8_pkg::QPTR_W-1:0]  wr_ptr;
  logic [u16u8_pkg::QPTR_W-1:0]  rd_ptr;
  logic [u16u8_pkg::QCNT_W-1:0]  count;
  logic                          do_push;
  logic                          do_pop;

  localparam logic [u16u8_pkg::QPTR_W-1:0] LAST_PTR =
    u16u8_pkg::QPTR_W'(u16u8_pkg::QUEUE_DEPTH - 1);
  localparam logic [u16u8_pkg::QCNT_W-1:0] FULL_COUNT =
    u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH);

  assign q_stat.full  = (count == FULL_COUNT);
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ hw/rtl/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Takes jobs from the queue and sends their bytes one word per cycle through
// an output register while the receiver keeps ready high.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                clk,
  input  logic                rst,
  input  u16u8_pkg::job_t     head,
  input  u16u8_pkg::q_stat_t  q_stat,
  output logic                pop,
  u16u8_byte_if.source        byte_out
);

  u16u8_pkg::job_t    cur;
  logic               busy;
  logic [1:0]         idx;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               run_last;
  u16u8_pkg::status_t status;
  logic               load;
  logic               fin;

  assign load = busy && (!out_valid || byte_out.ready);
  assign fin  = load && (idx == cur.last_idx);
  assign pop  = !q_stat.empty && (!busy || fin);

  assign byte_out.valid    = out_valid;
  assign byte_out.out_byte = out_byte;
  assign byte_out.run_last = run_last;
  assign byte_out.status   = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (byte_out.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (fin) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= cur.bytes[idx];
      run_last <= (idx == cur.last_idx);
      status   <= cur.status;
    end
    if (pop) begin
      cur <= head;
      idx <= 2'd0;
    end else if (load) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

@@ test/utf16_to_utf8_transcoder_top_test.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top_test
// Drives UTF-16 code units into the transcoder and checks every UTF-8 byte
// against a predictor that tracks the held high surrogate. Directed words
// cover the encoding boundaries and each malformed sequence. Random words
// follow, mostly well-formed text with some broken surrogate sequences. Both
// handshakes idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top_test;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_UNITS = 84;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0]         data;
    logic               last;
    u16u8_pkg::status_t status;
  } utf8_word_t;

  class utf8_scoreboard;
    utf8_word_t  byte_q[$];
    bit          high_held;
    logic [9:0]  held_high_bits;
    int unsigned failures;

    function void push_error(u16u8_pkg::status_t code);
      utf8_word_t w;
      w.data = 8'h00;
      w.last = 1'b1;
      w.status = code;
      byte_q = {byte_q, w};
    endfunction

    function void push_scalar(logic [20:0] cp);
      logic [7:0] seq [4];
      int n;
      int k;
      utf8_word_t w;
      if (cp < 21'h80) begin
        seq[0] = cp[7:0];
        n = 1;
      end else if (cp < 21'h800) begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
        n = 2;
      end else if (cp < 21'h10000) begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
        n = 3;
      end else begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        n = 4;
      end
      for (k = 0; k < n; k++) begin
        w.data = seq[k];
        w.last = (k == n - 1);
        w.status = u16u8_pkg::ST_OK;
        byte_q = {byte_q, w};
      end
    endfunction

    function void note_unit(logic [15:0] cu, logic eot);
      logic is_high;
      logic is_low;
      is_high = (cu[15:10] == u16u8_pkg::HIGH_TAG);
      is_low = (cu[15:10] == u16u8_pkg::LOW_TAG);
      if (high_held) begin
        high_held = 1'b0;
        if (is_low) push_scalar(21'h10000 + {1'b0, held_high_bits, cu[9:0]});
        else push_error(u16u8_pkg::ST_HIGH_NOT_LOW);
        held_high_bits = '0;
      end else if (is_high) begin
        if (eot) begin
          push_error(u16u8_pkg::ST_MISSING_LOW);
        end else begin
          high_held = 1'b1;
          held_high_bits = cu[9:0];
        end
      end else if (is_low) begin
        push_error(u16u8_pkg::ST_UNPAIRED_LOW);
      end else begin
        push_scalar({5'd0, cu});
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic [1:0] status);
      utf8_word_t w;
      if (byte_q.size() == 0) begin
        $error("unexpected word: out_byte %h run_last %b status %0d", data, last, status);
        failures++;
        return;
      end
      w = byte_q.pop_front();
      if (data !== w.data) begin
        $error("out_byte: expected %h, actual %h", w.data, data);
        failures++;
      end
      if (last !== w.last) begin
        $error("run_last: expected %b, actual %b", w.last, last);
        failures++;
      end
      if (status !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, status);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return byte_q.size();
    endfunction
  endclass

  bit clk;
  logic rst;

  u16u8_unit_if unit_in ();
  u16u8_byte_if byte_out ();

  utf16_to_utf8_transcoder_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .unit_in  (unit_in),
    .byte_out (byte_out)
  );

  utf8_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_off_cycles;
  int unsigned units_sent;
  int unsigned cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (unit_in.valid && unit_in.ready)
        sb.note_unit(unit_in.code_unit, unit_in.end_of_text);
      if (byte_out.valid && byte_out.ready)
        sb.check_byte(byte_out.out_byte, byte_out.run_last, byte_out.status);
    end
  end

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      byte_out.ready = 1'b0;
      hold_off_cycles--;
    end else begin
      byte_out.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_unit(input logic [15:0] cu, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      unit_in.valid = 1'b0;
      @(negedge clk);
    end
    unit_in.valid = 1'b1;
    unit_in.code_unit = cu;
    unit_in.end_of_text = eot;
    do @(posedge clk); while (unit_in.ready !== 1'b1);
    units_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] plain_unit();
    logic [15:0] cu;
    case ($urandom_range(2))
      0: cu = 16'($urandom_range(16'h7F));
      1: cu = 16'($urandom_range(16'h7FF, 16'h80));
      default: begin
        cu = 16'($urandom_range(16'hFFFF, 16'h800));
        if (cu[15:11] == 5'b11011) cu = cu ^ 16'h2000;
      end
    endcase
    return cu;
  endfunction

  function automatic logic [15:0] surrogate_unit(logic [5:0] tag);
    logic [9:0] bits;
    bits = 10'($urandom);
    return {tag, bits};
  endfunction

  task automatic send_random_run();
    int unsigned pick;
    logic eot;
    logic [15:0] raw;
    pick = $urandom_range(99);
    eot = ($urandom_range(7) == 0);
    raw = 16'($urandom);
    if (pick < 55) begin
      send_unit(plain_unit(), eot);
    end else if (pick < 80) begin
      send_unit(surrogate_unit(u16u8_pkg::HIGH_TAG), 1'b0);
      send_unit(surrogate_unit(u16u8_pkg::LOW_TAG), eot);
    end else if (pick < 86) begin
      send_unit(surrogate_unit(u16u8_pkg::HIGH_TAG), 1'b0);
      if (pick[0]) send_unit(plain_unit(), eot);
      else send_unit(surrogate_unit(u16u8_pkg::HIGH_TAG), eot);
    end else if (pick < 90) begin
      send_unit(surrogate_unit(u16u8_pkg::LOW_TAG), eot);
    end else if (pick < 93) begin
      send_unit(surrogate_unit(u16u8_pkg::HIGH_TAG), 1'b1);
    end else begin
      send_unit(raw, eot);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_goal;
    rst = 1'b1;
    unit_in.valid = 1'b0;
    unit_in.code_unit = '0;
    unit_in.end_of_text = 1'b0;
    byte_out.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD800, 1'b1);
    send_unit(16'hDA12, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hD955, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'h0041, 1'b1);
    send_unit(16'h5A5A, 1'b0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          @(posedge clk);
          hold_off_cycles = 300;
          @(negedge clk);
        end
        1: begin
          send_idle_pct = 79;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 79;
        end
        default: begin
          send_idle_pct = 14;
          stall_pct = 14;
        end
      endcase
      phase_goal = units_sent + PHASE_UNITS;
      while (units_sent < phase_goal) send_random_run();
    end

    unit_in.valid = 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
